### sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### sv/satq_pkg.sv
// Package for the sorted alarm timer queue: operation and result codes, types.
// Depends on nothing.
package satq_pkg;
   localparam int SlotsDefault = 16;
   localparam int MaxResults   = 16;
   localparam int QueueDepth   = 2;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_CANCEL = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RK_FIRED   = 2'd0,
      RK_ADDED   = 2'd1,
      RK_REFUSED = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] now_ms;
      logic [31:0] offset_ms;
      logic [1:0]  owner_kind;
      logic [31:0] owner_tag;
      logic [3:0]  cancel_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [3:0]  slot_handle;
      logic [1:0]  fired_owner_kind;
      logic [31:0] fired_owner_tag;
      logic [31:0] late_ms;
      logic        last;
   } rsp_type;
endpackage

### sv/satq_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on satq_pkg.
interface satq_req_if import satq_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface satq_rsp_if import satq_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/satq_front.sv
// Front end: accepts requests and queues them.
// Depends on satq_pkg.
module satq_front import satq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    q_valid,
   input  logic    q_pop,
   output req_type q_head
);
   localparam int AW = $clog2(QueueDepth);

   req_type             mem_ff [QueueDepth];
   logic [AW-1:0]       wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]         cnt_ff, cnt_in;
   logic                push;

   // Decoupling queue between front and back.
   assign req_ready = (cnt_ff != (AW+1)'(QueueDepth));
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_head    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push  ? wp_ff + 1'b1 : wp_ff;
      rp_in  = q_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= req_payload;
      end
   end
endmodule

### sv/satq_back.sv
// Back end: slot store, pending FIFO, sorted list and the tick/flush sequencer.
// Depends on satq_pkg.
module satq_back import satq_pkg::*; #(
   parameter int SLOTS = SlotsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_pop,
   input  req_type q_head,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FLUSH = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_TICK  = 5'b01000,
      ST_SHIFT = 5'b10000
   } state_type;

   state_type   st_ff, st_in;
   logic [63:0] dl_ff [SLOTS];
   logic [1:0]  ok_ff [SLOTS];
   logic [31:0] ot_ff [SLOTS];
   logic [SLOTS-1:0] del_ff, del_in, busy_ff, busy_in;
   logic [SW-1:0] ord_ff [SLOTS];
   logic [SW-1:0] ord_in [SLOTS];
   logic [SW-1:0] pf_ff [SLOTS];
   logic [CW-1:0] scnt_ff, scnt_in, pcnt_ff, pcnt_in;
   logic [CW-1:0] idx_ff, idx_in, pos_ff, pos_in;
   logic [4:0]    nf_ff, nf_in;
   logic          ov_ff, ov_in;
   rsp_type       out_ff, out_in;
   rsp_type       hold_ff, hold_in;

   logic [SW-1:0] free_s;
   logic          free_ok;
   logic          wr_slot;
   logic [SW-1:0] cur_s, pend_s;
   logic [63:0]   cur_dl, new_dl;
   logic          cur_del, expired;

   assign rsp_valid   = ov_ff;
   assign rsp_payload = out_ff;

   // Lowest free slot.
   always_comb begin
      free_s  = '0;
      free_ok = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_s  = SW'(i);
            free_ok = 1'b1;
         end
      end
   end

   assign pend_s  = pf_ff[idx_ff[SW-1:0]];
   assign cur_s   = ord_ff[pos_ff[SW-1:0]];
   assign cur_dl  = dl_ff[cur_s];
   assign cur_del = del_ff[cur_s];
   assign expired = !(q_head.now_ms < cur_dl);
   assign new_dl  = q_head.now_ms + {{32{q_head.offset_ms[31]}}, q_head.offset_ms};

   // Sequencer: add and cancel are handled from idle, flush and tick step per entry.
   always_comb begin
      st_in   = st_ff;
      del_in  = del_ff;
      busy_in = busy_ff;
      ord_in  = ord_ff;
      scnt_in = scnt_ff;
      pcnt_in = pcnt_ff;
      idx_in  = idx_ff;
      pos_in  = pos_ff;
      nf_in   = nf_ff;
      ov_in   = ov_ff && !rsp_ready;
      out_in  = out_ff;
      hold_in = hold_ff;
      q_pop   = 1'b0;
      wr_slot = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid && !ov_in) begin
               case (op_type'(q_head.op))
                  OP_ADD: begin
                     q_pop  = 1'b1;
                     ov_in  = 1'b1;
                     out_in = '0;
                     out_in.last = 1'b1;
                     if (!free_ok || pcnt_ff >= CW'(SLOTS)) begin
                        out_in.result_kind = RK_REFUSED;
                     end else begin
                        wr_slot = 1'b1;
                        out_in.result_kind = RK_ADDED;
                        out_in.slot_handle = 4'(free_s);
                        del_in[free_s]  = 1'b0;
                        busy_in[free_s] = 1'b1;
                        pcnt_in = pcnt_ff + 1'b1;
                     end
                  end
                  OP_CANCEL: begin
                     q_pop = 1'b1;
                     if ({3'b000, q_head.cancel_handle} < 7'(SLOTS)) begin
                        if (busy_ff[SW'(q_head.cancel_handle)]) begin
                           del_in[SW'(q_head.cancel_handle)] = 1'b1;
                        end
                     end
                  end
                  OP_FLUSH: begin
                     idx_in = '0;
                     pos_in = '0;
                     st_in  = ST_FLUSH;
                  end
                  default: begin
                     pos_in = '0;
                     nf_in  = '0;
                     st_in  = ST_TICK;
                  end
               endcase
            end
         end
         ST_FLUSH: begin
            // Start inserting the next pending slot, or finish when none is left or the list is full.
            if (idx_ff >= pcnt_ff || scnt_ff >= CW'(SLOTS)) begin
               pcnt_in = '0;
               q_pop   = 1'b1;
               st_in   = ST_IDLE;
            end else begin
               pos_in = '0;
               st_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Find the insert position one entry a cycle.
            if (pos_ff < scnt_ff && dl_ff[pend_s] > cur_dl) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               for (int j = 1; j < SLOTS; j++) begin
                  if (CW'(j) > pos_ff && CW'(j) <= scnt_ff) begin
                     ord_in[j] = ord_ff[j-1];
                  end
               end
               ord_in[pos_ff[SW-1:0]] = pend_s;
               scnt_in = scnt_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
               st_in   = ST_FLUSH;
            end
         end
         ST_TICK: begin
            // Walk the head; pos counts freed entries.
            if (pos_ff >= scnt_ff ||
                (!cur_del && (!expired || nf_ff == 5'(MaxResults)))) begin
               // Release the held result, if any, marked last, then compact the list.
               if (nf_ff == '0) begin
                  st_in = ST_SHIFT;
               end else if (!ov_in) begin
                  ov_in       = 1'b1;
                  out_in      = hold_ff;
                  out_in.last = 1'b1;
                  st_in       = ST_SHIFT;
               end
            end else if (cur_del) begin
               busy_in[cur_s] = 1'b0;
               del_in[cur_s]  = 1'b0;
               pos_in = pos_ff + 1'b1;
            end else if (nf_ff == '0 || !ov_in) begin
               // Hold this alarm so the final one can be marked last; the
               // alarm held before it goes out now.
               if (nf_ff != '0) begin
                  ov_in  = 1'b1;
                  out_in = hold_ff;
               end
               hold_in.result_kind      = RK_FIRED;
               hold_in.slot_handle      = 4'(cur_s);
               hold_in.fired_owner_kind = ok_ff[cur_s];
               hold_in.fired_owner_tag  = ot_ff[cur_s];
               hold_in.late_ms          = 32'(q_head.now_ms - cur_dl);
               hold_in.last             = 1'b0;
               busy_in[cur_s] = 1'b0;
               del_in[cur_s]  = 1'b0;
               pos_in = pos_ff + 1'b1;
               nf_in  = nf_ff + 1'b1;
            end
         end
         default: begin
            // Shift the sorted list down by the freed count.
            for (int j = 0; j < SLOTS; j++) begin
               if (CW'(j) + pos_ff < CW'(SLOTS)) begin
                  ord_in[j] = ord_ff[SW'(CW'(j) + pos_ff)];
               end
            end
            scnt_in = scnt_ff - pos_ff;
            q_pop   = 1'b1;
            st_in   = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         del_ff  <= '0;
         busy_ff <= '0;
         scnt_ff <= '0;
         pcnt_ff <= '0;
         ov_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         del_ff  <= del_in;
         busy_ff <= busy_in;
         scnt_ff <= scnt_in;
         pcnt_ff <= pcnt_in;
         ov_ff   <= ov_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      nf_ff   <= nf_in;
      out_ff  <= out_in;
      hold_ff <= hold_in;
      ord_ff  <= ord_in;
      if (wr_slot) begin
         dl_ff[free_s] <= new_dl;
         ok_ff[free_s] <= q_head.owner_kind;
         ot_ff[free_s] <= q_head.owner_tag;
         pf_ff[pcnt_ff[SW-1:0]] <= free_s;
      end
   end
endmodule

### sv/sorted_alarm_timer_queue.sv
// Top level of the sorted alarm timer queue.
// Depends on satq_pkg, satq_if, satq_front and satq_back.
//
//   channel | dir | carries
//   req     | in  | op, now_ms, offset_ms, owner_kind, owner_tag, cancel_handle
//   rsp     | out | result_kind, slot_handle, owner kind/tag, late_ms, last
//
// Add and cancel are handled straight from idle in the back end; flush runs
// the one-entry-per-cycle position scan for each pending slot. Tick walks
// the sorted list from its head and waits longer per fired alarm while the
// result register is still occupied. Reset is synchronous and frees all
// slots at once. A two-entry queue lets requests enter while the back works.
module sorted_alarm_timer_queue import satq_pkg::*; #(
   parameter int SLOTS = SlotsDefault
) (
   input logic clock,
   input logic reset,
   satq_req_if.sink   req,
   satq_rsp_if.source rsp
);
   logic    q_valid, q_pop;
   req_type q_head;

   satq_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_payload(req.payload),
      .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
   );

   satq_back #(.SLOTS(SLOTS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
   );
endmodule

### sv/satq_checker.sv
// Port-level checker for the sorted alarm timer queue, bound to the top level.
// Depends on satq_pkg, satq_if and assert_macros.svh.
`include "assert_macros.svh"
module satq_checker import satq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);
   logic not_fired, refused;

   // Result kind decodes, kept short for the assertions below.
   assign not_fired = rsp_valid && rsp_payload.result_kind != RK_FIRED;
   assign refused   = rsp_valid && rsp_payload.result_kind == RK_REFUSED;

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   `CHK_IMPL(a_kind, clock, reset, rsp_valid, rsp_payload.result_kind != 2'd3, "bad result kind")
   `CHK_IMPL(a_add_last, clock, reset, not_fired, rsp_payload.last, "add result not last")
   `CHK_IMPL(a_refuse_zero, clock, reset, refused, rsp_payload.slot_handle == '0, "refusal has slot")
   `CHK_IMPL(a_ready_known, clock, reset, 1'b1, !$isunknown(req_ready), "request ready unknown")
endmodule

bind sorted_alarm_timer_queue satq_checker u_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

### verif/sorted_alarm_timer_queue_tb.sv
// Testbench for the sorted alarm timer queue: directed table, then random requests.
// Depends on satq_pkg, satq_if and the sorted_alarm_timer_queue RTL.
module sorted_alarm_timer_queue_tb;
   import satq_pkg::*;

   localparam int NumSlots = 16;
   localparam int IdleLimit = 20000;
   localparam int HoldLength = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   satq_req_if req_ch();
   satq_rsp_if rsp_ch();

   sorted_alarm_timer_queue #(.SLOTS(NumSlots)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always #10 clock = ~clock;

   // Shadow state of the queue.
   logic [63:0] alarm_deadline [NumSlots];
   logic [1:0]  alarm_kind [NumSlots];
   logic [31:0] alarm_tag [NumSlots];
   bit          alarm_deleted [NumSlots];
   bit          alarm_busy [NumSlots];
   int          sorted_slots [$];
   int          pending_slots [$];

   rsp_type expected_rsps [$];
   int      mismatch_count = 0;
   int      sender_idle_pct = 0;
   int      receiver_idle_pct = 0;
   int      hold_requests = 0;
   int      hold_served = 0;
   int      hold_cycles = 0;
   int      quiet_cycles = 0;
   bit      timed_out = 0;

   // One directed row: a request plus an optional typed-in expectation.
   typedef struct {
      req_type req;
      bit      has_fixed;
      rsp_type fixed;
   } row_type;

   function automatic rsp_type make_rsp(result_kind_type kind, logic [3:0] slot,
                                        logic [1:0] okind, logic [31:0] otag,
                                        logic [31:0] late, logic last_flag);
      rsp_type r;
      r.result_kind = kind;
      r.slot_handle = slot;
      r.fired_owner_kind = okind;
      r.fired_owner_tag = otag;
      r.late_ms = late;
      r.last = last_flag;
      return r;
   endfunction

   // Computes the results of one request and advances the shadow state.
   task automatic predict_alarm_results(input req_type r);
      int free_slot;
      int pos;
      int fired;
      int s;
      rsp_type fires [$];
      free_slot = -1;
      case (op_type'(r.op))
         OP_ADD: begin
            for (int i = NumSlots - 1; i >= 0; i--)
               if (!alarm_busy[i]) free_slot = i;
            if (free_slot < 0 || pending_slots.size() >= NumSlots) begin
               expected_rsps.push_back(make_rsp(RK_REFUSED, '0, '0, '0, '0, 1'b1));
            end else begin
               alarm_deadline[free_slot] = r.now_ms + {{32{r.offset_ms[31]}}, r.offset_ms};
               alarm_kind[free_slot] = r.owner_kind;
               alarm_tag[free_slot] = r.owner_tag;
               alarm_deleted[free_slot] = 0;
               alarm_busy[free_slot] = 1;
               pending_slots.push_back(free_slot);
               expected_rsps.push_back(make_rsp(RK_ADDED, free_slot[3:0], '0, '0, '0, 1'b1));
            end
         end
         OP_CANCEL: begin
            if (alarm_busy[r.cancel_handle]) alarm_deleted[r.cancel_handle] = 1;
         end
         OP_FLUSH: begin
            foreach (pending_slots[p]) begin
               if (sorted_slots.size() >= NumSlots) break;
               s = pending_slots[p];
               pos = 0;
               while (pos < sorted_slots.size() &&
                      alarm_deadline[s] > alarm_deadline[sorted_slots[pos]])
                  pos++;
               sorted_slots.insert(pos, s);
            end
            pending_slots.delete();
         end
         default: begin
            fired = 0;
            while (sorted_slots.size() > 0) begin
               s = sorted_slots[0];
               if (!alarm_deleted[s]) begin
                  if (r.now_ms < alarm_deadline[s] || fired >= MaxResults) break;
                  fires.push_back(make_rsp(RK_FIRED, s[3:0], alarm_kind[s], alarm_tag[s],
                                           32'(r.now_ms - alarm_deadline[s]), 1'b0));
                  fired++;
               end
               alarm_busy[s] = 0;
               alarm_deleted[s] = 0;
               void'(sorted_slots.pop_front());
            end
            if (fires.size() > 0) fires[fires.size() - 1].last = 1'b1;
            foreach (fires[i]) expected_rsps.push_back(fires[i]);
         end
      endcase
   endtask

   // Offers one request and waits for its acceptance, with random gaps.
   // Valid stays high on return so a following request can go back to back.
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_alarm_results(r);
      @(negedge clock);
   endtask

   function automatic req_type random_request(int bias);
      req_type r;
      int pick;
      r.now_ms = {$urandom, $urandom};
      r.offset_ms = $urandom;
      r.owner_kind = 2'($urandom);
      r.owner_tag = $urandom;
      r.cancel_handle = 4'($urandom);
      pick = $urandom_range(99);
      // Mostly add/flush/tick around a moving clock so alarms do fire.
      if (pick < bias) begin
         r.now_ms = 64'd1_000_000 + 64'($urandom_range(5000));
         r.offset_ms = $urandom_range(4000) - 32'd2000;
      end
      pick = $urandom_range(99);
      r.op = pick < 45 ? OP_ADD : pick < 58 ? OP_CANCEL : pick < 78 ? OP_FLUSH : OP_TICK;
      return r;
   endfunction

   // Stops offering and waits until every expected result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_rsps.size() > 0 && !timed_out) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Result checker on the rising edge.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result %p", rsp_ch.payload);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_ch.payload !== exp_rsp) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Result differs: expected %p, got %p", exp_rsp, rsp_ch.payload);
            end
         end
      end
   end

   // Receiver stall pattern, with a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_cycles <= HoldLength - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Watchdog on cycles with no accepted request or result.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (!reset && quiet_cycles >= IdleLimit) begin
         timed_out = 1;
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      row_type table_rows [$];
      row_type row;
      req_type r;
      int plan [3][2] = '{'{31, 82}, '{82, 31}, '{0, 0}};

      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      foreach (alarm_busy[i]) begin
         alarm_busy[i] = 0;
         alarm_deleted[i] = 0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: first add after reset lands in slot 0, extremes, refusal.
      row = '{default: '0};
      row.req.op = OP_ADD;
      row.req.now_ms = '1;
      row.req.offset_ms = 32'h8000_0000;
      row.req.owner_kind = 2'd3;
      row.req.owner_tag = '1;
      row.has_fixed = 1;
      row.fixed = make_rsp(RK_ADDED, '0, '0, '0, '0, 1'b1);
      table_rows.push_back(row);
      row.has_fixed = 0;
      row.req.now_ms = '0;
      row.req.offset_ms = 32'h7fff_ffff;
      row.req.owner_kind = '0;
      row.req.owner_tag = '0;
      table_rows.push_back(row);
      row.req.offset_ms = '0;
      for (int i = 0; i < 14; i++) begin
         row.req.now_ms = 64'd100 + 64'(i);
         row.req.owner_tag = 32'h1000 + 32'(i);
         row.req.owner_kind = 2'(i % 3);
         table_rows.push_back(row);
      end
      // Seventeenth add finds every slot busy.
      row.has_fixed = 1;
      row.fixed = make_rsp(RK_REFUSED, '0, '0, '0, '0, 1'b1);
      table_rows.push_back(row);
      row.has_fixed = 0;
      row.req.op = OP_CANCEL;
      row.req.cancel_handle = 4'd15;
      table_rows.push_back(row);
      row.req.cancel_handle = 4'd3;
      table_rows.push_back(row);
      row.req.op = OP_FLUSH;
      table_rows.push_back(row);
      // Tick at the far end fires all live alarms, capped at sixteen.
      row.req.op = OP_TICK;
      row.req.now_ms = 64'hffff_ffff_ffff_fffe;
      table_rows.push_back(row);
      row.req.now_ms = '1;
      table_rows.push_back(row);
      row.req.op = OP_CANCEL;
      row.req.cancel_handle = 4'd0;
      table_rows.push_back(row);

      foreach (table_rows[i]) begin
         send_request(table_rows[i].req);
         if (table_rows[i].has_fixed &&
             expected_rsps[expected_rsps.size() - 1] !== table_rows[i].fixed) begin
            mismatch_count++;
            $display("Predictor differs from table row %0d", i);
         end
      end
      wait_drained();

      // Random phases under the three idle patterns.
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = plan[ph][0];
         receiver_idle_pct = plan[ph][1];
         for (int n = 0; n < 70; n++) begin
            if (ph == 0 && n == 20) hold_requests++;
            r = random_request(85);
            send_request(r);
         end
         wait_drained();
      end

      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
